// ===== design/sfv_pkg.sv =====
// ----------------------------------------------------------------------------
// sfv_pkg
// Types and constants shared by the stream frame validator modules.
// ----------------------------------------------------------------------------
package sfv_pkg;

    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_ADDR_W = 3;

    localparam logic [15:0] ACK_PAYLOAD_BYTES = 16'd8;

    typedef enum logic [0:0] {
        CMD_CHECK   = 1'b0,
        CMD_RESTART = 1'b1
    } sfv_cmd_t;

    typedef enum logic [2:0] {
        FT_REQUEST  = 3'd0,
        FT_RESPONSE = 3'd1,
        FT_DATA     = 3'd2,
        FT_ACK      = 3'd3,
        FT_ERROR    = 3'd4,
        FT_CANCEL   = 3'd5,
        FT_COMPLETE = 3'd6,
        FT_UNKNOWN  = 3'd7
    } sfv_type_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ARGUMENT = 3'd1,
        ST_STATE    = 3'd2,
        ST_SERVICE  = 3'd3,
        ST_FORMAT   = 3'd4,
        ST_SEQUENCE = 3'd5,
        ST_MSGTYPE  = 3'd6,
        ST_LIMIT    = 3'd7
    } sfv_status_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_STREAM_ARMED  = 3'd0,
        REG_EXP_SERVICE   = 3'd1,
        REG_EXP_REQ_ID    = 3'd2,
        REG_BYTE_BUDGET   = 3'd3,
        REG_CTRL_PAY_MAX  = 3'd4,
        REG_DATA_PAY_MAX  = 3'd5
    } sfv_reg_t;

    typedef struct packed {
        sfv_cmd_t    cmd;
        logic        payload_valid;
        logic [7:0]  frame_service;
        logic [63:0] frame_request_id;
        logic [7:0]  frame_flags;
        logic [31:0] frame_sequence;
        logic [2:0]  frame_type;
        logic [15:0] payload_len;
        logic [31:0] ack_word_first;
        logic [31:0] ack_word_second;
    } sfv_in_t;

    typedef struct packed {
        sfv_status_t status;
        logic        stream_complete;
        logic        stream_failed;
        logic [63:0] bytes_so_far;
        logic [31:0] sequence_expected;
    } sfv_out_t;

    typedef struct packed {
        logic        stream_armed;
        logic [7:0]  expected_service;
        logic [63:0] expected_request_id;
        logic [63:0] byte_budget;
        logic [15:0] control_payload_max;
        logic [15:0] data_payload_max;
    } sfv_cfg_t;

    typedef struct packed {
        logic [63:0] byte_total;
        logic [31:0] next_seq;
        logic        done_flag;
        logic        fail_flag;
    } sfv_state_t;

endpackage

// ===== design/stream_frame_validator.sv =====
// ----------------------------------------------------------------------------
// stream_frame_validator
// Validates frame headers of one request stream against configured values
// and keeps the byte total, expected sequence and completion/failure flags.
//
//   channel  dir  handshake              payload
//   s_       in   s_valid / s_ready      sfv_in_t  (one frame or restart)
//   m_       out  m_valid / m_ready      sfv_out_t (status and stream state)
//   cfg_     in   cfg_we, no wait        cfg_addr, cfg_wdata
//
// One request per cycle sustained while the result is not stalled; the result
// passes through the input register, then the result register.
// Checks and the state update run in one pass between the two registers.
// A stalled result holds the result register and the request behind it.
// Synchronous active-low reset clears the stream state, valid flags and config.
// ----------------------------------------------------------------------------
module stream_frame_validator (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  sfv_pkg::sfv_in_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output sfv_pkg::sfv_out_t              m_data,
    input  logic                           cfg_we,
    input  logic [sfv_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [sfv_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import sfv_pkg::*;

    sfv_cfg_t    cfg;
    sfv_in_t     in_reg;
    logic        in_valid_reg;
    logic        in_valid_next;
    sfv_out_t    out_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    sfv_state_t  state_reg;
    sfv_state_t  state_next;
    sfv_status_t chk_status;
    logic        advance;
    logic        s_take;

    sfv_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    sfv_check u_check (
        .req        (in_reg),
        .cfg        (cfg),
        .state      (state_reg),
        .status     (chk_status),
        .state_next (state_next)
    );

    assign advance        = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready        = !in_valid_reg || advance;
    assign s_take         = s_valid && s_ready;
    assign in_valid_next  = s_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg.status            <= (in_reg.cmd == CMD_RESTART) ? ST_OK : chk_status;
            out_reg.stream_complete   <= state_next.done_flag;
            out_reg.stream_failed     <= state_next.fail_flag;
            out_reg.bytes_so_far      <= state_next.byte_total;
            out_reg.sequence_expected <= state_next.next_seq;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef ASSERT_OFF
    a_fail_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.fail_flag && !(advance && in_reg.cmd == CMD_RESTART) |=> state_reg.fail_flag)
        else $error("failure flag dropped without a restart");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("input stalled with an empty result register");

    a_total_adds: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_reg.cmd == CMD_CHECK && chk_status == ST_OK
        |=> state_reg.byte_total == $past(state_reg.byte_total) + 64'($past(in_reg.payload_len)))
        else $error("byte total not advanced by the payload length");

    a_seq_no_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_reg.cmd == CMD_CHECK && chk_status == ST_OK |=> state_reg.next_seq != 32'd0)
        else $error("expected sequence wrapped");
`endif

endmodule

// ===== design/sfv_cfg.sv =====
// ----------------------------------------------------------------------------
// sfv_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module sfv_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [sfv_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [sfv_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output sfv_pkg::sfv_cfg_t                 cfg
);
    import sfv_pkg::*;

    sfv_cfg_t cfg_reg;
    sfv_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (sfv_reg_t'(cfg_addr))
                REG_STREAM_ARMED: cfg_next.stream_armed        = cfg_wdata[0];
                REG_EXP_SERVICE:  cfg_next.expected_service    = cfg_wdata[7:0];
                REG_EXP_REQ_ID:   cfg_next.expected_request_id = cfg_wdata;
                REG_BYTE_BUDGET:  cfg_next.byte_budget         = cfg_wdata;
                REG_CTRL_PAY_MAX: cfg_next.control_payload_max = cfg_wdata[15:0];
                REG_DATA_PAY_MAX: cfg_next.data_payload_max    = cfg_wdata[15:0];
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/sfv_check.sv =====
// ----------------------------------------------------------------------------
// sfv_check
// Header checks for one request and the stream state it leaves behind.
// ----------------------------------------------------------------------------
module sfv_check (
    input  sfv_pkg::sfv_in_t     req,
    input  sfv_pkg::sfv_cfg_t    cfg,
    input  sfv_pkg::sfv_state_t  state,
    output sfv_pkg::sfv_status_t status,
    output sfv_pkg::sfv_state_t  state_next
);
    import sfv_pkg::*;

    sfv_status_t type_status;
    logic        terminal;
    logic        seq_bad;
    logic        over_budget;
    logic [64:0] byte_sum;
    logic        fail_set;
    logic        pass;

    always_comb begin
        terminal    = 1'b0;
        type_status = ST_OK;
        unique case (sfv_type_t'(req.frame_type))
            FT_REQUEST, FT_RESPONSE: begin
                type_status = (req.payload_len <= cfg.control_payload_max) ? ST_OK : ST_LIMIT;
            end
            FT_DATA: begin
                type_status = (req.payload_len <= cfg.data_payload_max) ? ST_OK : ST_LIMIT;
            end
            FT_ACK: begin
                if (req.payload_len != ACK_PAYLOAD_BYTES || req.ack_word_first == 32'd0 ||
                    req.ack_word_second == 32'd0) begin
                    type_status = ST_FORMAT;
                end
            end
            FT_ERROR: begin
                terminal    = 1'b1;
                type_status = (req.payload_len <= cfg.control_payload_max) ? ST_OK : ST_LIMIT;
            end
            FT_CANCEL, FT_COMPLETE: begin
                terminal    = 1'b1;
                type_status = (req.payload_len == 16'd0) ? ST_OK : ST_FORMAT;
            end
            FT_UNKNOWN: begin
                type_status = ST_MSGTYPE;
            end
        endcase
    end

    assign seq_bad     = (req.frame_sequence != state.next_seq) || (&state.next_seq);
    assign byte_sum    = {1'b0, state.byte_total} + {49'd0, req.payload_len};
    assign over_budget = byte_sum > {1'b0, cfg.byte_budget};

    always_comb begin
        status   = ST_OK;
        fail_set = 1'b0;
        pass     = 1'b0;
        priority if (!req.payload_valid) begin
            status = ST_ARGUMENT;
        end else if (!cfg.stream_armed || state.fail_flag) begin
            status = ST_STATE;
        end else if (state.done_flag) begin
            status   = ST_STATE;
            fail_set = 1'b1;
        end else if (req.frame_service != cfg.expected_service) begin
            status   = ST_SERVICE;
            fail_set = 1'b1;
        end else if (req.frame_request_id != cfg.expected_request_id) begin
            status   = ST_STATE;
            fail_set = 1'b1;
        end else if (req.frame_flags != 8'd0) begin
            status   = ST_FORMAT;
            fail_set = 1'b1;
        end else if (seq_bad) begin
            status   = ST_SEQUENCE;
            fail_set = 1'b1;
        end else if (type_status != ST_OK) begin
            status   = type_status;
            fail_set = 1'b1;
        end else if (over_budget) begin
            status   = ST_LIMIT;
            fail_set = 1'b1;
        end else begin
            pass = 1'b1;
        end
    end

    always_comb begin
        state_next = state;
        unique case (req.cmd)
            CMD_RESTART: begin
                if (cfg.stream_armed) begin
                    state_next = '0;
                end
            end
            CMD_CHECK: begin
                if (pass) begin
                    state_next.byte_total = byte_sum[63:0];
                    state_next.next_seq   = state.next_seq + 32'd1;
                    state_next.done_flag  = terminal;
                end
                if (fail_set) begin
                    state_next.fail_flag = 1'b1;
                end
            end
        endcase
    end

endmodule
